/* src/ccfd_pkg.sv */
// ----------------------------------------------------------------------------
// ccfd_pkg: shared types and constants of the can command frame dispatcher
// Beat layouts, queue entry layout, frame classes, outcome and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfd_pkg;

  // sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int WHEEL_COUNT = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_CMD_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESTOP_ID     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CFG_ID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENGAGE_CODE  = 3'd3;

  // register reset values
  localparam logic [ID_W-1:0] RST_MOTOR_CMD_ID = 11'h101;
  localparam logic [ID_W-1:0] RST_ESTOP_ID     = 11'h102;
  localparam logic [ID_W-1:0] RST_GAIN_CFG_ID  = 11'h103;
  localparam logic [7:0]      RST_ENGAGE_CODE  = 8'd1;

  // frame classes found by the front end
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_MOTOR = 2'd1;
  localparam logic [1:0] CLS_ESTOP = 2'd2;
  localparam logic [1:0] CLS_GAIN  = 2'd3;

  // result outcome codes
  localparam logic [2:0] OUT_IGNORED    = 3'd0;
  localparam logic [2:0] OUT_TARGETS    = 3'd1;
  localparam logic [2:0] OUT_SUPPRESSED = 3'd2;
  localparam logic [2:0] OUT_ENGAGED    = 3'd3;
  localparam logic [2:0] OUT_RELEASED   = 3'd4;
  localparam logic [2:0] OUT_GAIN_WRITE = 3'd5;
  localparam logic [2:0] OUT_GAIN_REJ   = 3'd6;

  // received frame beat
  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic [7:0]      byte0;
    logic [7:0]      byte1;
    logic [7:0]      byte2;
    logic [7:0]      byte3;
    logic [7:0]      byte4;
    logic [7:0]      byte5;
    logic [7:0]      byte6;
    logic [7:0]      byte7;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [2:0]         outcome;
    logic signed [15:0] target_a;
    logic signed [15:0] target_b;
    logic signed [15:0] target_c;
    logic signed [15:0] target_d;
    logic [1:0]         gain_motor;
    logic [1:0]         gain_select;
    logic [31:0]        gain_bits;
    logic               estop_latched;
  } out_beat_t;

  // classified frame held in the queue, data[i] is payload byte i
  typedef struct packed {
    logic [1:0]      cls;
    logic            engage;
    logic            gain_ok;
    logic [7:0][7:0] data;
  } q_entry_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* src/can_command_frame_dispatcher_core.sv */
// ----------------------------------------------------------------------------
// can_command_frame_dispatcher_core: CAN command frame decoder top level
//
// Input channel in_valid/in_stall/in_data carries one received standard-ID
// frame per beat. A front end matches the identifier against the motor,
// estop and gain registers and pushes the classified frame into a 16-entry
// receive queue. A back end pops frames in order, applies the estop latch
// and writes one result beat per frame on out_valid/out_stall/out_data.
// Config writes on cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; indexes past the register list are dropped.
// A frame accepted on the input is written into a queue entry and is then
// popped into the result register. Throughput: one frame per cycle while
// out_stall is low, limited by the single queue read port feeding the result register.
// When out_stall is high with a valid result, the result holds, the back end
// stops popping and the queue fills; in_stall rises once all 16 queue entries are used.
// Reset (synchronous, rst_n low) empties the queue, clears the estop latch
// and loads the identifier registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module can_command_frame_dispatcher_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [ccfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ccfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  ccfd_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output ccfd_pkg::out_beat_t             out_data
);

  ccfd_pkg::q_status_t q_status;
  ccfd_pkg::q_entry_t  push_entry;
  ccfd_pkg::q_entry_t  head_entry;
  logic                push;
  logic                pop;

  // classify and push
  ccfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // receive queue
  ccfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_status   (q_status)
  );

  // execute and register the result
  ccfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // engage always leaves the latch set, release always clears it
  a_engage_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == ccfd_pkg::OUT_ENGAGED) |-> out_data.estop_latched)
    else $error("engage result without latch set");

  a_release_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == ccfd_pkg::OUT_RELEASED) |-> !out_data.estop_latched)
    else $error("release result with latch set");

  // targets only go out when the latch was clear
  a_targets_unlatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == ccfd_pkg::OUT_TARGETS) |-> !out_data.estop_latched)
    else $error("targets issued while estop latched");

  // a popped frame always produces a result beat next cycle
  a_pop_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("popped frame produced no result");

endmodule

`default_nettype wire

/* src/ccfd_front.sv */
// ----------------------------------------------------------------------------
// ccfd_front: configuration registers and frame classification
// Holds the identifier registers, matches each incoming frame and pushes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfd_front (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [ccfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ccfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  ccfd_pkg::in_beat_t              in_data,
  input  ccfd_pkg::q_status_t             q_status,
  output logic                            push,
  output ccfd_pkg::q_entry_t              push_entry
);

  logic [ccfd_pkg::ID_W-1:0] cmd_id_r;
  logic [ccfd_pkg::ID_W-1:0] estop_id_r;
  logic [ccfd_pkg::ID_W-1:0] gain_id_r;
  logic [7:0]                engage_code_r;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_id_r      <= ccfd_pkg::RST_MOTOR_CMD_ID;
      estop_id_r    <= ccfd_pkg::RST_ESTOP_ID;
      gain_id_r     <= ccfd_pkg::RST_GAIN_CFG_ID;
      engage_code_r <= ccfd_pkg::RST_ENGAGE_CODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccfd_pkg::REG_MOTOR_CMD_ID: cmd_id_r      <= cfg_data;
        ccfd_pkg::REG_ESTOP_ID:     estop_id_r    <= cfg_data;
        ccfd_pkg::REG_GAIN_CFG_ID:  gain_id_r     <= cfg_data;
        ccfd_pkg::REG_ENGAGE_CODE:  engage_code_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // back-pressure when the queue is full
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // classify, motor command wins over estop, estop over gain config
  always_comb begin
    push_entry.cls = ccfd_pkg::CLS_NONE;
    if (in_data.frame_id == cmd_id_r) begin
      push_entry.cls = ccfd_pkg::CLS_MOTOR;
    end else if (in_data.frame_id == estop_id_r) begin
      push_entry.cls = ccfd_pkg::CLS_ESTOP;
    end else if (in_data.frame_id == gain_id_r) begin
      push_entry.cls = ccfd_pkg::CLS_GAIN;
    end
    push_entry.engage  = (in_data.byte0 == engage_code_r);
    push_entry.gain_ok = (in_data.byte0 < 8'(ccfd_pkg::WHEEL_COUNT)) &&
                         (in_data.byte1 < 8'd4);
    push_entry.data[0] = in_data.byte0;
    push_entry.data[1] = in_data.byte1;
    push_entry.data[2] = in_data.byte2;
    push_entry.data[3] = in_data.byte3;
    push_entry.data[4] = in_data.byte4;
    push_entry.data[5] = in_data.byte5;
    push_entry.data[6] = in_data.byte6;
    push_entry.data[7] = in_data.byte7;
  end

endmodule

`default_nettype wire

/* src/ccfd_queue.sv */
// ----------------------------------------------------------------------------
// ccfd_queue: receive queue between front and back ends
// Register-file fifo with one write and one read port, read at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfd_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  ccfd_pkg::q_entry_t   push_entry,
  input  wire                  pop,
  output ccfd_pkg::q_entry_t   head_entry,
  output ccfd_pkg::q_status_t  q_status
);

  ccfd_pkg::q_entry_t               mem_r [ccfd_pkg::QUEUE_DEPTH];
  logic [ccfd_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [ccfd_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [ccfd_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [ccfd_pkg::QPTR_W-1:0]      rd_ptr_nxt;
  logic [ccfd_pkg::QCNT_W-1:0]      count_r;
  logic [ccfd_pkg::QCNT_W-1:0]      count_nxt;

  localparam logic [ccfd_pkg::QPTR_W-1:0] PTR_LAST =
    ccfd_pkg::QPTR_W'(ccfd_pkg::QUEUE_DEPTH - 1);
  localparam logic [ccfd_pkg::QCNT_W-1:0] CNT_FULL =
    ccfd_pkg::QCNT_W'(ccfd_pkg::QUEUE_DEPTH);

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_entry     = mem_r[rd_ptr_r];
  assign q_status.full  = (count_r == CNT_FULL);
  assign q_status.empty = (count_r == '0);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ccfd_back.sv */
// ----------------------------------------------------------------------------
// ccfd_back: frame execution and result register
// Pops classified frames, applies the estop latch and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfd_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ccfd_pkg::q_entry_t   head_entry,
  input  ccfd_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output ccfd_pkg::out_beat_t  out_data
);

  logic                 estop_r;
  logic                 estop_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  ccfd_pkg::out_beat_t  out_data_r;
  ccfd_pkg::out_beat_t  res;

  // take a frame when the result register is free or being drained
  assign pop           = !q_status.empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  // decode the head frame
  always_comb begin
    res       = '0;
    estop_nxt = estop_r;
    case (head_entry.cls)
      ccfd_pkg::CLS_MOTOR: begin
        if (estop_r) begin
          res.outcome = ccfd_pkg::OUT_SUPPRESSED;
        end else begin
          res.outcome  = ccfd_pkg::OUT_TARGETS;
          res.target_a = {head_entry.data[1], head_entry.data[0]};
          res.target_b = {head_entry.data[3], head_entry.data[2]};
          res.target_c = {head_entry.data[5], head_entry.data[4]};
          res.target_d = {head_entry.data[7], head_entry.data[6]};
        end
      end
      ccfd_pkg::CLS_ESTOP: begin
        estop_nxt   = head_entry.engage;
        res.outcome = head_entry.engage ? ccfd_pkg::OUT_ENGAGED : ccfd_pkg::OUT_RELEASED;
      end
      ccfd_pkg::CLS_GAIN: begin
        if (head_entry.gain_ok) begin
          res.outcome     = ccfd_pkg::OUT_GAIN_WRITE;
          res.gain_motor  = head_entry.data[0][1:0];
          res.gain_select = head_entry.data[1][1:0];
          res.gain_bits   = {head_entry.data[5], head_entry.data[4],
                             head_entry.data[3], head_entry.data[2]};
        end else begin
          res.outcome = ccfd_pkg::OUT_GAIN_REJ;
        end
      end
      default: res.outcome = ccfd_pkg::OUT_IGNORED;
    endcase
    res.estop_latched = estop_nxt;
  end

  // latch and valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      estop_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        estop_r <= estop_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
